[hdl/aopl_pkg.sv]
// Package for the arrival order presence list block.
// Holds sizes, payload and control structs, codes and the count color table.
// No dependencies.
package aopl_pkg;

  localparam int MAX_AGENTS = 16;
  localparam int INDEX_BITS = 10;

  // Slot pointer and count widths follow from the list depth.
  localparam int PTR_W = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int CNT_W = $clog2(MAX_AGENTS + 1);

  localparam int ID_W    = 10;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int COLOR_W = 8;

  localparam logic ACT_PUSH   = 1'b0;
  localparam logic ACT_COMMIT = 1'b1;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_ADDED     = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_BELOW     = 2'd3
  } status_e;

  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] agent_id;
  } in_item_t;

  typedef struct packed {
    kind_e                kind;
    status_e              status;
    logic [INDEX_BITS-1:0] agent_index;
    logic [POS_W-1:0]     position;
    logic [COUNT_W-1:0]   present_count;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN_OLD,
    S_SCAN_NEW,
    S_EMIT,
    S_EMPTY
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // take the request, clear the commit counters
    logic push_exec;   // resolve a push and load its result
    logic old_step;    // check one entry of the old list against pending
    logic new_step;    // append one pending entry if not yet taken
    logic finish;      // install the new list, empty the pending list
    logic emit_entry;  // load one committed entry as a result
    logic emit_empty;  // load the empty list marker
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_commit;   // the offered request is a commit
    logic slot_free;   // the output register can take a result this cycle
    logic old_done;    // every old entry has been checked
    logic new_done;    // every pending entry has been visited
    logic n_zero;      // the new list is empty
    logic emit_last;   // the entry being emitted is the final one
  } ctrl_sts_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  // Display color chosen from the committed count.
  function automatic color_t count_color(input logic [CNT_W-1:0] count);
    color_t c;
    if (count == '0) begin
      c = '{red: 8'd189, green: 8'd131, blue: 8'd126};
    end else if (count == CNT_W'(2)) begin
      c = '{red: 8'd198, green: 8'd186, blue: 8'd58};
    end else begin
      c = '{red: 8'd44, green: 8'd83, blue: 8'd120};
    end
    return c;
  endfunction

endpackage

[hdl/aopl_ctrl.sv]
// Controller state machine of the arrival order presence list block.
// Sequences push and commit requests; depends on aopl_pkg.
module aopl_ctrl
  import aopl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_commit ? S_SCAN_OLD : S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts_i.slot_free) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN_OLD: begin
        if (sts_i.old_done) begin
          state_d = S_SCAN_NEW;
        end
      end
      S_SCAN_NEW: begin
        if (sts_i.new_done) begin
          state_d = sts_i.n_zero ? S_EMPTY : S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.slot_free && sts_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts_i.slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      S_PUSH: begin
        cmd_o.push_exec = sts_i.slot_free;
      end
      S_SCAN_OLD: begin
        cmd_o.old_step = !sts_i.old_done;
      end
      S_SCAN_NEW: begin
        cmd_o.new_step = !sts_i.new_done;
        cmd_o.finish   = sts_i.new_done;
      end
      S_EMIT: begin
        cmd_o.emit_entry = sts_i.slot_free;
      end
      S_EMPTY: begin
        cmd_o.emit_empty = sts_i.slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[hdl/aopl_dpath.sv]
// Datapath of the arrival order presence list block: both lists, taken
// flags, scan counters, offset register and output register. Uses aopl_pkg.
module aopl_dpath
  import aopl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  in_item_t        in_item_i,
  input  logic            cfg_valid_i,
  input  logic [ID_W-1:0] cfg_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o,
  input  ctrl_cmd_t       cmd_i,
  output ctrl_sts_t       sts_o
);

  logic [INDEX_BITS-1:0] present_q [MAX_AGENTS];
  logic [INDEX_BITS-1:0] pending_q [MAX_AGENTS];
  logic [CNT_W-1:0]      present_len_q, pending_len_q;
  logic [MAX_AGENTS-1:0] taken_q;
  logic [ID_W-1:0]       offset_q, id_q;
  logic [CNT_W-1:0]      i_q, j_q, n_q, k_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  // Push resolution.
  logic                  below;
  logic [ID_W-1:0]       diff;
  logic [INDEX_BITS-1:0] rid;
  logic [MAX_AGENTS-1:0] push_match;
  logic [PTR_W-1:0]      match_pos;
  logic                  dup, full;
  status_e               push_status;

  // Commit scan.
  logic [INDEX_BITS-1:0] old_cur, new_cur;
  logic [MAX_AGENTS-1:0] old_match;
  logic                  new_free;
  color_t                push_color, list_color;

  assign below = id_q < offset_q;
  assign diff  = id_q - offset_q;
  assign rid   = diff[INDEX_BITS-1:0];
  assign full  = pending_len_q == CNT_W'(MAX_AGENTS);

  assign old_cur  = present_q[i_q[PTR_W-1:0]];
  assign new_cur  = pending_q[j_q[PTR_W-1:0]];
  assign new_free = !taken_q[j_q[PTR_W-1:0]];

  // Pending entries are unique, so at most one slot matches and the
  // matching slot number is an OR over the hits.
  always_comb begin
    match_pos = '0;
    for (int j = 0; j < MAX_AGENTS; j++) begin
      push_match[j] = (CNT_W'(j) < pending_len_q) && (pending_q[j] == rid);
      old_match[j]  = (CNT_W'(j) < pending_len_q) && !taken_q[j] &&
                      (pending_q[j] == old_cur);
      if (push_match[j]) begin
        match_pos = match_pos | PTR_W'(j);
      end
    end
  end

  assign dup = |push_match;

  always_comb begin
    if (below) begin
      push_status = ST_BELOW;
    end else if (dup) begin
      push_status = ST_DUPLICATE;
    end else if (full) begin
      push_status = ST_FULL;
    end else begin
      push_status = ST_ADDED;
    end
  end

  assign push_color = count_color(present_len_q);
  assign list_color = count_color(present_len_q);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q      <= '0;
      present_len_q <= '0;
      pending_len_q <= '0;
      taken_q       <= '0;
      i_q           <= '0;
      j_q           <= '0;
      n_q           <= '0;
      k_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        offset_q <= cfg_data_i;
      end
      if (cmd_i.latch) begin
        i_q     <= '0;
        j_q     <= '0;
        n_q     <= '0;
        k_q     <= '0;
        taken_q <= '0;
      end
      if (cmd_i.push_exec && (push_status == ST_ADDED)) begin
        pending_len_q <= pending_len_q + CNT_W'(1);
      end
      if (cmd_i.old_step) begin
        i_q <= i_q + CNT_W'(1);
        if (|old_match) begin
          taken_q <= taken_q | old_match;
          n_q     <= n_q + CNT_W'(1);
        end
      end
      if (cmd_i.new_step) begin
        j_q <= j_q + CNT_W'(1);
        if (new_free && (n_q < CNT_W'(MAX_AGENTS))) begin
          n_q <= n_q + CNT_W'(1);
        end
      end
      if (cmd_i.finish) begin
        present_len_q <= n_q;
        pending_len_q <= '0;
        taken_q       <= '0;
      end
      if (cmd_i.emit_entry) begin
        k_q <= k_q + CNT_W'(1);
      end
      if (cmd_i.push_exec || cmd_i.emit_entry || cmd_i.emit_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // List storage and payload registers. The new list is built in place:
  // the write slot never passes the old entry being read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      id_q <= in_item_i.agent_id;
    end
    if (cmd_i.push_exec && (push_status == ST_ADDED)) begin
      pending_q[pending_len_q[PTR_W-1:0]] <= rid;
    end
    if (cmd_i.old_step && (|old_match)) begin
      present_q[n_q[PTR_W-1:0]] <= old_cur;
    end
    if (cmd_i.new_step && new_free && (n_q < CNT_W'(MAX_AGENTS))) begin
      present_q[n_q[PTR_W-1:0]] <= new_cur;
    end
    if (cmd_i.push_exec) begin
      out_q.kind          <= KIND_PUSH;
      out_q.status        <= push_status;
      out_q.agent_index   <= below ? '0 : rid;
      case (push_status)
        ST_ADDED:     out_q.position <= POS_W'(pending_len_q);
        ST_DUPLICATE: out_q.position <= POS_W'(match_pos);
        default:      out_q.position <= '0;
      endcase
      out_q.present_count <= COUNT_W'(present_len_q);
      out_q.red           <= push_color.red;
      out_q.green         <= push_color.green;
      out_q.blue          <= push_color.blue;
      out_q.last          <= 1'b1;
    end
    if (cmd_i.emit_entry) begin
      out_q.kind          <= KIND_ENTRY;
      out_q.status        <= ST_ADDED;
      out_q.agent_index   <= present_q[k_q[PTR_W-1:0]];
      out_q.position      <= POS_W'(k_q);
      out_q.present_count <= COUNT_W'(present_len_q);
      out_q.red           <= list_color.red;
      out_q.green         <= list_color.green;
      out_q.blue          <= list_color.blue;
      out_q.last          <= sts_o.emit_last;
    end
    if (cmd_i.emit_empty) begin
      out_q.kind          <= KIND_EMPTY;
      out_q.status        <= ST_ADDED;
      out_q.agent_index   <= '0;
      out_q.position      <= '0;
      out_q.present_count <= '0;
      out_q.red           <= list_color.red;
      out_q.green         <= list_color.green;
      out_q.blue          <= list_color.blue;
      out_q.last          <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign sts_o.in_commit = in_item_i.action == ACT_COMMIT;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.old_done  = i_q == present_len_q;
  assign sts_o.new_done  = j_q == pending_len_q;
  assign sts_o.n_zero    = n_q == '0;
  assign sts_o.emit_last = (k_q + CNT_W'(1)) == present_len_q;

endmodule

[hdl/arrival_order_presence_list.sv]
// Top level of the arrival order presence list block.
// Joins aopl_ctrl and aopl_dpath; uses aopl_pkg.
//
//   Channel  Handshake                  Payload       Direction
//   in       in_valid_i / in_ready_o    in_item_i     push or commit request
//   out      out_valid_o / out_ready_i  out_item_o    push status, entry or empty
//   cfg      cfg_valid_i / cfg_ready_o  cfg_data_i    index offset write
//
// A push is registered in the idle state and resolved against all pending
// slots in parallel in the push state once the output register is free.
// A commit is run by the scan sequencer, which visits one old entry, then
// one pending entry, then one result a cycle; results wait on a free output.
// Reset empties both lists, clears the taken flags and sets the offset to
// zero; list contents need no clearing pass. A stalled output holds its
// result in the output register, and the emit steps wait on it.
module arrival_order_presence_list
  import aopl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [ID_W-1:0] cfg_data_i
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The offset register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // The controller only sequences; every list, counter and result register
  // lives in the datapath.
  aopl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  aopl_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
